@@ rtl/core/esv_pkg.sv @@
`default_nettype none

package esv_pkg;

  // Longest local part or domain that still passes.
  localparam int MAX_PART_LEN_DEF = 256;

  // Character codes that the rules look at.
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_DIG_0 = 8'h30;
  localparam logic [7:0] CH_DIG_9 = 8'h39;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  // One input request: a raw character and its end-of-address mark.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } esv_item_t;

  // One result: the canonical character and, on the last one, the verdict.
  typedef struct packed {
    logic [7:0] lower_ch;
    logic       end_mark;
    logic       valid_res;
  } esv_res_t;

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= CH_LO_A) && (c <= CH_LO_Z);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_DIG_0) && (c <= CH_DIG_9);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_lower(c) || is_digit(c);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? c + CASE_OFFSET : c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/esv_ifs.sv @@
`default_nettype none

// Character channel into the validator.
interface esv_in_if import esv_pkg::*; ();
  logic      valid;
  logic      ready;
  esv_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Result channel out of the validator.
interface esv_out_if import esv_pkg::*; ();
  logic     valid;
  logic     ready;
  esv_res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/email_syntax_validator.sv @@
`default_nettype none

// Streaming e-mail address syntax checker. Characters enter one per request on in_port,
// the final one flagged by last; every character yields one registered result on
// out_port, lowercased, and the result of the last character carries valid_res, the
// verdict on the whole address (1 only if the address uses a-z, 0-9, '-', '.', '@',
// has no "..", no "--", exactly one '@', local part and domain of 1 to MAX_PART_LEN
// characters, a dot in the domain, and labels that begin with a letter and end with a
// letter or digit). One character is taken every cycle while the skid entry is empty: the
// rule flags and the two saturating length counters update from each accepted character,
// and a two-entry output buffer lets one more character in after the result side stalls.
// State returns to its reset values after each last character, so addresses may follow
// back to back.
module email_syntax_validator import esv_pkg::*; #(
  parameter int MAX_PART_LEN = MAX_PART_LEN_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  esv_in_if.sink     in_port,
  esv_out_if.source  out_port
);

  localparam int LenW = $clog2(MAX_PART_LEN + 2);
  localparam logic [LenW-1:0] LenMax = LenW'(MAX_PART_LEN);
  localparam logic [LenW-1:0] LenSat = LenW'(MAX_PART_LEN + 1);

  // Address state.
  logic            failed_r, failed_nxt;
  logic            in_domain_r, in_domain_nxt;
  logic [7:0]      prev_char_r;
  logic            dot_seen_r, dot_seen_nxt;
  logic [LenW-1:0] local_len_r, local_len_nxt;
  logic [LenW-1:0] domain_len_r, domain_len_nxt;

  // Output buffer.
  esv_res_t out_r, skid_r, res;
  logic     out_vld_r, skid_vld_r;

  logic       accept, pop;
  logic [7:0] c;
  logic       is_at, is_dot, allowed, at_start, rule_broken, dom_inc, verdict;

  assign in_port.ready  = !skid_vld_r;
  assign accept         = in_port.valid && !skid_vld_r;
  assign pop            = out_vld_r && out_port.ready;
  assign out_port.valid = out_vld_r;
  assign out_port.data  = out_r;

  // Rule checks on the incoming character.
  always_comb begin
    c        = to_lower(in_port.data.ch);
    is_at    = (c == CH_AT);
    is_dot   = (c == CH_DOT);
    allowed  = is_alnum(c) || (c == CH_DASH) || is_dot || is_at;
    at_start = (prev_char_r == CH_NUL) || (prev_char_r == CH_DOT) || (prev_char_r == CH_AT);

    if (!allowed) begin
      rule_broken = 1'b1;
    end else if (is_dot || is_at) begin
      rule_broken = !is_alnum(prev_char_r) || (is_at && in_domain_r);
    end else begin
      rule_broken = ((c == CH_DASH) && (prev_char_r == CH_DASH)) || (at_start && !is_lower(c));
    end

    failed_nxt    = failed_r || rule_broken;
    in_domain_nxt = in_domain_r || is_at;
    dot_seen_nxt  = dot_seen_r || (is_dot && in_domain_r);

    // The '@' that opens the domain is not counted in either part.
    dom_inc = in_domain_nxt && !(is_at && (prev_char_r != CH_AT) &&
                                 (domain_len_r == '0) && !dot_seen_nxt);

    local_len_nxt  = local_len_r;
    domain_len_nxt = domain_len_r;
    if (dom_inc) begin
      if (domain_len_r < LenSat) domain_len_nxt = domain_len_r + 1'b1;
    end else if (!in_domain_nxt) begin
      if (local_len_r < LenSat) local_len_nxt = local_len_r + 1'b1;
    end

    verdict = !failed_nxt && in_domain_nxt && dot_seen_nxt && is_alnum(c) &&
              (local_len_nxt != '0) && (local_len_nxt <= LenMax) &&
              (domain_len_nxt != '0) && (domain_len_nxt <= LenMax);

    res.lower_ch  = c;
    res.end_mark  = in_port.data.last;
    res.valid_res = in_port.data.last && verdict;
  end

  // State update; a last character puts everything back to reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      failed_r     <= 1'b0;
      in_domain_r  <= 1'b0;
      prev_char_r  <= CH_NUL;
      dot_seen_r   <= 1'b0;
      local_len_r  <= '0;
      domain_len_r <= '0;
    end else if (accept) begin
      if (in_port.data.last) begin
        failed_r     <= 1'b0;
        in_domain_r  <= 1'b0;
        prev_char_r  <= CH_NUL;
        dot_seen_r   <= 1'b0;
        local_len_r  <= '0;
        domain_len_r <= '0;
      end else begin
        failed_r     <= failed_nxt;
        in_domain_r  <= in_domain_nxt;
        prev_char_r  <= c;
        dot_seen_r   <= dot_seen_nxt;
        local_len_r  <= local_len_nxt;
        domain_len_r <= domain_len_nxt;
      end
    end
  end

  // Output and skid valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) skid_vld_r <= 1'b0;
    end else if (accept) begin
      if (out_vld_r && !pop) skid_vld_r <= 1'b1;
      else out_vld_r <= 1'b1;
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  // Output and skid payload.
  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) out_r <= skid_r;
    end else if (accept) begin
      if (out_vld_r && !pop) skid_r <= res;
      else out_r <= res;
    end
  end

endmodule

`default_nettype wire
